### src/rsr_pkg.sv
// Shared constants and controller/datapath interface types for the resampler.
`default_nettype none
package rsr_pkg;

  localparam int MAX_WORLDS = 32;
  localparam int IDX_W      = $clog2(MAX_WORLDS);
  localparam int CNT_W      = $clog2(MAX_WORLDS + 1);
  localparam int VAL_W      = 32;
  // Sum of MAX_WORLDS values of VAL_W bits
  localparam int SUM_W      = VAL_W + CNT_W;

  localparam logic [1:0] REG_WORLD_COUNT = 2'd0;
  localparam logic [1:0] REG_ROULETTE    = 2'd1;
  localparam logic [1:0] REG_SPLIT       = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic sum_acc;
    logic cls_eval;
    logic smp_rd;
    logic smp_mul;
    logic smp_hi;
    logic walk_rd;
    logic walk_cmp;
    logic asg_init;
    logic asg_step;
    logic out_rd;
    logic out_mul;
    logic out_hi;
    logic div_step;
    logic emit;
  } rsr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_load;
    logic idx_end;
    logic np_zero;
    logic walk_end;
    logic smp_end;
    logic asg_done;
    logic need_div;
    logic div_done;
  } rsr_status_t;

endpackage
`default_nettype wire

### src/rsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

### src/rsr_ctrl.sv
// Controller state machine sequencing load, sum, classify, sample, assign and output.
`default_nettype none
module rsr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire rsr_pkg::rsr_status_t st,
  output rsr_pkg::rsr_cmd_t         cmd
);
  import rsr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SUM_RD, S_SUM_ACC, S_CLS_RD, S_CLS_EVAL, S_SMP_CHK,
    S_SMP_RD, S_SMP_MUL, S_SMP_HI, S_WALK_RD, S_WALK_CMP,
    S_ASG_INIT, S_ASG, S_OUT_RD, S_OUT_MUL, S_OUT_HI, S_DIV, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (st.last_load) state_nxt = S_SUM_RD;
        end
      end
      S_SUM_RD:  state_nxt = S_SUM_ACC;
      S_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        state_nxt   = st.idx_end ? S_CLS_RD : S_SUM_RD;
      end
      S_CLS_RD:  state_nxt = S_CLS_EVAL;
      S_CLS_EVAL: begin
        cmd.cls_eval = 1'b1;
        state_nxt    = st.idx_end ? S_SMP_CHK : S_CLS_RD;
      end
      S_SMP_CHK: state_nxt = st.np_zero ? S_ASG_INIT : S_SMP_RD;
      S_SMP_RD: begin
        cmd.smp_rd = 1'b1;
        state_nxt  = S_SMP_MUL;
      end
      S_SMP_MUL: begin
        cmd.smp_mul = 1'b1;
        state_nxt   = S_SMP_HI;
      end
      S_SMP_HI: begin
        cmd.smp_hi = 1'b1;
        state_nxt  = S_WALK_RD;
      end
      S_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = S_WALK_CMP;
      end
      S_WALK_CMP: begin
        cmd.walk_cmp = 1'b1;
        if (st.walk_end) begin
          state_nxt = st.smp_end ? S_ASG_INIT : S_SMP_RD;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end
      S_ASG_INIT: begin
        cmd.asg_init = 1'b1;
        state_nxt    = S_ASG;
      end
      S_ASG: begin
        cmd.asg_step = 1'b1;
        if (st.asg_done) state_nxt = S_OUT_RD;
      end
      S_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = S_OUT_MUL;
      end
      S_OUT_MUL: begin
        cmd.out_mul = 1'b1;
        state_nxt   = st.need_div ? S_OUT_HI : S_EMIT;
      end
      S_OUT_HI: begin
        cmd.out_hi = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = st.idx_end ? S_IDLE : S_OUT_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### src/rsr_datapath.sv
// Datapath: stores, sums, copy counting, slot assignment, weight divider, result registers.
`default_nettype none
module rsr_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [rsr_pkg::VAL_W-1:0]   cfg_wdata,
  input  wire logic [rsr_pkg::VAL_W-1:0]   in_importance,
  input  wire logic [rsr_pkg::VAL_W-1:0]   in_old_weight,
  input  wire logic [rsr_pkg::VAL_W-1:0]   in_uniform_sample,
  input  wire rsr_pkg::rsr_cmd_t           cmd,
  output rsr_pkg::rsr_status_t             st,
  output logic                             out_valid,
  output logic [rsr_pkg::IDX_W-1:0]        out_slot,
  output logic [rsr_pkg::IDX_W-1:0]        out_source_world,
  output logic                             out_source_valid,
  output logic                             out_participated,
  output logic [rsr_pkg::VAL_W-1:0]        out_new_weight,
  output logic                             out_last
);
  import rsr_pkg::*;

  localparam int HI_W  = SUM_W - VAL_W;        // upper bits of a sum
  localparam int NUM_W = VAL_W + HI_W + 1;     // upper numerator word
  localparam int DEN_W = VAL_W + CNT_W;

  // Configuration
  logic [CNT_W-1:0] wc_r;
  logic [VAL_W-1:0] roul_r, split_r;
  logic [CNT_W-1:0] n_eff;

  // Counters and sums
  logic [CNT_W-1:0] lc_r, idx_r, np_r, j_r, pi_r, f_r, cnt_r;
  logic [SUM_W-1:0] total_r, psum_r, lowc_r;
  logic [IDX_W-1:0] bit_r;

  // Per-world tables
  logic [CNT_W-1:0] copy_r  [MAX_WORLDS];
  logic [IDX_W-1:0] tab_r   [MAX_WORLDS];
  logic [IDX_W-1:0] plist_r [MAX_WORLDS];
  logic             part_r  [MAX_WORLDS];
  logic             aval_r  [MAX_WORLDS];

  // Sample and divider registers
  logic [VAL_W-1:0]   u_r, ulo_r, old_r, n0_r, q_r, nw_r;
  logic [2*VAL_W-1:0] a_r;
  logic [NUM_W-1:0]   uhi_r;
  logic [DEN_W-1:0]   d_r;
  logic [DEN_W-1:0]   rem_r;
  logic               sat_r;

  // RAM ports
  logic [IDX_W-1:0] load_addr, imp_raddr, smp_raddr, wgt_raddr;
  logic [VAL_W-1:0] imp_rdata, smp_rdata, wgt_rdata;
  logic [CNT_W-1:0] lc_inc;

  // Clamp the world count
  always_comb begin
    if (wc_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (wc_r > CNT_W'(MAX_WORLDS)) begin
      n_eff = CNT_W'(MAX_WORLDS);
    end else begin
      n_eff = wc_r;
    end
  end

  assign load_addr = (lc_r >= CNT_W'(MAX_WORLDS)) ? '0 : lc_r[IDX_W-1:0];
  assign lc_inc    = {1'b0, load_addr} + CNT_W'(1);

  logic [IDX_W-1:0] k_idx, src_idx;
  logic             need;
  assign k_idx   = idx_r[IDX_W-1:0];
  assign src_idx = tab_r[k_idx];
  assign need    = part_r[k_idx] && aval_r[k_idx];

  // Read address selection
  always_comb begin
    imp_raddr = k_idx;
    if (cmd.walk_rd) imp_raddr = plist_r[pi_r[IDX_W-1:0]];
    else if (cmd.out_rd) imp_raddr = src_idx;
    smp_raddr = j_r[IDX_W-1:0];
    wgt_raddr = need ? src_idx : k_idx;
  end

  rsr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_WORLDS)) u_imp_ram (
    .clk(clk), .we(cmd.load), .waddr(load_addr), .wdata(in_importance),
    .raddr(imp_raddr), .rdata(imp_rdata)
  );
  rsr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_WORLDS)) u_wgt_ram (
    .clk(clk), .we(cmd.load), .waddr(load_addr), .wdata(in_old_weight),
    .raddr(wgt_raddr), .rdata(wgt_rdata)
  );
  rsr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_WORLDS)) u_smp_ram (
    .clk(clk), .we(cmd.load), .waddr(load_addr), .wdata(in_uniform_sample),
    .raddr(smp_raddr), .rdata(smp_rdata)
  );

  // Classification terms
  logic [SUM_W:0]   prod;
  logic             die, spl, is_p;
  assign prod = (SUM_W+1)'(imp_rdata) * (SUM_W+1)'(n_eff);
  assign die  = (prod < (SUM_W+1)'(total_r)) && (imp_rdata < roul_r);
  assign spl  = (prod > (SUM_W+1)'(total_r)) && (imp_rdata > split_r);
  assign is_p = die || spl;

  // Interval test for one sample against one participant
  logic [NUM_W-1:0] lowc_x, upc;
  logic             above, hit;
  assign lowc_x = NUM_W'(lowc_r);
  assign upc    = lowc_x + NUM_W'(imp_rdata);
  assign above  = (uhi_r > lowc_x) || ((uhi_r == lowc_x) && (ulo_r != '0));
  assign hit    = above && (uhi_r < upc);

  // Upper numerator word and divider step
  logic [NUM_W-1:0] n1;
  logic [DEN_W:0]   r2;
  logic             ge;
  assign n1 = NUM_W'(old_r) * NUM_W'(psum_r[SUM_W-1:VAL_W]) + NUM_W'(a_r[2*VAL_W-1:VAL_W]);
  assign r2 = {rem_r, n0_r[VAL_W-1]};
  assign ge = r2 >= {1'b0, d_r};

  // Status
  always_comb begin
    st.last_load = lc_inc >= n_eff;
    st.idx_end   = (idx_r + CNT_W'(1)) == n_eff;
    st.np_zero   = (np_r == '0);
    st.walk_end  = (pi_r + CNT_W'(1)) == np_r;
    st.smp_end   = (j_r + CNT_W'(1)) == np_r;
    st.asg_done  = idx_r >= n_eff;
    st.need_div  = need;
    st.div_done  = sat_r || (bit_r == IDX_W'(VAL_W - 1));
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r    <= CNT_W'(MAX_WORLDS);
      roul_r  <= '0;
      split_r <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WORLD_COUNT: wc_r    <= cfg_wdata[CNT_W-1:0];
        REG_ROULETTE:    roul_r  <= cfg_wdata;
        REG_SPLIT:       split_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r  <= '0;
      idx_r <= '0;
      np_r  <= '0;
      j_r   <= '0;
      pi_r  <= '0;
      f_r   <= '0;
      cnt_r <= '0;
      bit_r <= '0;
      sat_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        lc_r  <= st.last_load ? '0 : lc_inc;
        idx_r <= '0;
        np_r  <= '0;
      end
      if (cmd.sum_acc) idx_r <= st.idx_end ? '0 : idx_r + CNT_W'(1);
      if (cmd.cls_eval) begin
        idx_r <= st.idx_end ? '0 : idx_r + CNT_W'(1);
        if (is_p) np_r <= np_r + CNT_W'(1);
        j_r <= '0;
      end
      if (cmd.smp_hi) pi_r <= '0;
      if (cmd.walk_cmp) begin
        pi_r <= pi_r + CNT_W'(1);
        if (st.walk_end) j_r <= j_r + CNT_W'(1);
      end
      if (cmd.asg_init) begin
        idx_r <= '0;
        f_r   <= '0;
        cnt_r <= copy_r[0];
      end
      // Walk worlds, placing each extra copy in the lowest free slot
      if (cmd.asg_step) begin
        if (st.asg_done) begin
          idx_r <= '0;
        end else if (cnt_r <= CNT_W'(1)) begin
          idx_r <= idx_r + CNT_W'(1);
          cnt_r <= copy_r[IDX_W'(idx_r + CNT_W'(1))];
        end else if (f_r >= n_eff) begin
          cnt_r <= CNT_W'(1);
        end else if (aval_r[f_r[IDX_W-1:0]]) begin
          f_r <= f_r + CNT_W'(1);
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
          f_r   <= f_r + CNT_W'(1);
        end
      end
      if (cmd.out_hi) begin
        bit_r <= '0;
        sat_r <= (d_r == '0) || (n1 >= NUM_W'(d_r));
      end
      if (cmd.div_step) bit_r <= bit_r + IDX_W'(1);
      if (cmd.emit) idx_r <= st.idx_end ? '0 : idx_r + CNT_W'(1);
    end
  end

  // Sums
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      total_r <= '0;
      psum_r  <= '0;
    end
    if (cmd.sum_acc) total_r <= total_r + SUM_W'(imp_rdata);
    if (cmd.cls_eval && is_p) psum_r <= psum_r + SUM_W'(imp_rdata);
    if (cmd.smp_hi) lowc_r <= '0;
    if (cmd.walk_cmp) lowc_r <= SUM_W'(upc);
  end

  // Per-world tables
  always_ff @(posedge clk) begin
    if (cmd.cls_eval) begin
      part_r[k_idx] <= is_p;
      copy_r[k_idx] <= is_p ? '0 : CNT_W'(1);
      if (is_p) plist_r[np_r[IDX_W-1:0]] <= k_idx;
    end
    if (cmd.walk_cmp && hit) begin
      copy_r[plist_r[pi_r[IDX_W-1:0]]] <= copy_r[plist_r[pi_r[IDX_W-1:0]]] + CNT_W'(1);
    end
    if (cmd.asg_init) begin
      for (int k = 0; k < MAX_WORLDS; k++) begin
        aval_r[k] <= (copy_r[k] != '0);
        tab_r[k]  <= IDX_W'(k);
      end
    end
    if (cmd.asg_step && !st.asg_done && (cnt_r > CNT_W'(1)) && (f_r < n_eff)
        && !aval_r[f_r[IDX_W-1:0]]) begin
      aval_r[f_r[IDX_W-1:0]] <= 1'b1;
      tab_r[f_r[IDX_W-1:0]]  <= k_idx;
    end
  end

  // Sample product, numerator and divider
  always_ff @(posedge clk) begin
    if (cmd.smp_mul) begin
      a_r <= (2*VAL_W)'(smp_rdata) * (2*VAL_W)'(psum_r[VAL_W-1:0]);
      u_r <= smp_rdata;
    end
    if (cmd.smp_hi) begin
      uhi_r <= NUM_W'(u_r) * NUM_W'(psum_r[SUM_W-1:VAL_W]) + NUM_W'(a_r[2*VAL_W-1:VAL_W]);
      ulo_r <= a_r[VAL_W-1:0];
    end
    if (cmd.out_mul) begin
      old_r <= wgt_rdata;
      nw_r  <= wgt_rdata;
      a_r   <= (2*VAL_W)'(wgt_rdata) * (2*VAL_W)'(psum_r[VAL_W-1:0]);
      d_r   <= DEN_W'(np_r) * DEN_W'(imp_rdata);
    end
    if (cmd.out_hi) begin
      rem_r <= DEN_W'(n1);
      n0_r  <= a_r[VAL_W-1:0];
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if (sat_r) begin
        nw_r <= '1;
      end else begin
        rem_r <= ge ? DEN_W'(r2 - {1'b0, d_r}) : DEN_W'(r2);
        n0_r  <= {n0_r[VAL_W-2:0], 1'b0};
        q_r   <= {q_r[VAL_W-2:0], ge};
        nw_r  <= {q_r[VAL_W-2:0], ge};
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
    if (cmd.emit) begin
      out_slot         <= k_idx;
      out_source_world <= aval_r[k_idx] ? src_idx : '0;
      out_source_valid <= aval_r[k_idx];
      out_participated <= part_r[k_idx];
      out_new_weight   <= nw_r;
      out_last         <= st.idx_end;
    end
  end

endmodule
`default_nettype wire

### src/roulette_split_resampler.sv
// Top level of the roulette-and-splitting resampler.
//
// Usage: write world_count (index 0), roulette_threshold (1) and
// split_threshold (2) through cfg_we/cfg_index/cfg_wdata while idle.
// Load one item per world: an item is taken when start is high and busy is
// low, one item per cycle during the load phase. The item that completes
// the round starts the compute phase and raises busy.
// Compute: sum the total, classify the worlds plus one check state, walk the
// samples over P participants (each step reads the importance memory once),
// assign the slots, then read out each slot; a filled participating slot
// goes through the 32-step weight divider, which gives an all-ones weight
// when that divisor saturates.
// Results come out in slot order, one per out_valid pulse; out_last marks
// the final slot. The receiver cannot stall; each result stands one cycle.
// Reset clears the load count, the controller and the configuration
// registers to their defaults; world stores hold stale data until written.
`default_nettype none
module roulette_split_resampler (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [rsr_pkg::VAL_W-1:0] cfg_wdata,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [rsr_pkg::VAL_W-1:0] in_importance,
  input  wire logic [rsr_pkg::VAL_W-1:0] in_old_weight,
  input  wire logic [rsr_pkg::VAL_W-1:0] in_uniform_sample,
  output logic                           out_valid,
  output logic [rsr_pkg::IDX_W-1:0]      out_slot,
  output logic [rsr_pkg::IDX_W-1:0]      out_source_world,
  output logic                           out_source_valid,
  output logic                           out_participated,
  output logic [rsr_pkg::VAL_W-1:0]      out_new_weight,
  output logic                           out_last
);
  import rsr_pkg::*;

  rsr_cmd_t    cmd;
  rsr_status_t st;

  rsr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .st(st), .cmd(cmd)
  );

  rsr_datapath u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_importance(in_importance), .in_old_weight(in_old_weight),
    .in_uniform_sample(in_uniform_sample),
    .cmd(cmd), .st(st),
    .out_valid(out_valid), .out_slot(out_slot),
    .out_source_world(out_source_world), .out_source_valid(out_source_valid),
    .out_participated(out_participated), .out_new_weight(out_new_weight),
    .out_last(out_last)
  );

endmodule
`default_nettype wire
